// ===== sv/lrut_pkg.sv =====
`default_nettype none
package lrut_pkg;

	localparam int ENTRIES  = 64;
	localparam int KEY_BITS = 48;
	localparam int KEY_W    = 48;
	localparam int SLOT_W   = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int OSLOT_W  = 6;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [OSLOT_W-1:0] slot;
		logic               displaced;
		logic [KEY_W-1:0]   displaced_key;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [SLOT_W-1:0]   slot;
		logic                valid;
	} entry_t;

	typedef struct packed {
		logic   shift_hit;
		logic   shift_all;
		logic   clear;
		entry_t head;
	} ctl_t;

	typedef struct packed {
		logic   hit;
		entry_t hit_entry;
		entry_t last;
	} stat_t;

	function automatic logic [ENTRIES-1:0] prefix_or(input logic [ENTRIES-1:0] v);
		logic [ENTRIES-1:0] r;
		r = v;
		for (int d = 1; d < ENTRIES; d = d * 2) begin
			r = r | (r >> d);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lrut_cell.sv =====
`default_nettype none
module lrut_cell import lrut_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire entry_t              prev,
	input  wire logic                shift,
	input  wire logic                clear,
	input  wire logic [KEY_BITS-1:0] key,
	output entry_t                   cur,
	output logic                     match
);

	logic [KEY_BITS-1:0] key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                valid_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q  <= prev.key;
			slot_q <= prev.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	assign cur   = '{key: key_q, slot: slot_q, valid: valid_q};
	assign match = valid_q && (key_q == key);

endmodule
`default_nettype wire

// ===== sv/lrut_chain.sv =====
`default_nettype none
module lrut_chain import lrut_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire ctl_t                ctl,
	output stat_t                    stat
);

	entry_t             cur [ENTRIES];
	entry_t             prev [ENTRIES];
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] upto;
	logic [ENTRIES-1:0] shift;
	entry_t             sel;

	assign upto = prefix_or(match);

	genvar i;
	generate
		for (i = 0; i < ENTRIES; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign prev[i] = ctl.head;
			end else begin : g_link
				assign prev[i] = cur[i-1];
			end
			assign shift[i] = ctl.shift_all || (ctl.shift_hit && upto[i]);
			lrut_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.prev  (prev[i]),
				.shift (shift[i]),
				.clear (ctl.clear),
				.key   (key),
				.cur   (cur[i]),
				.match (match[i])
			);
		end
	endgenerate

	always_comb begin
		sel = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			if (match[j]) begin
				sel = sel | cur[j];
			end
		end
	end

	assign stat = '{hit: |match, hit_entry: sel, last: cur[ENTRIES-1]};

endmodule
`default_nettype wire

// ===== sv/lru_tag_replacement_unit.sv =====
// Tag and replacement logic of a fully associative cache with LRU order.
// Request channel: req_valid / req_stall carry req (cmd, key). cmd lookup
// returns hit and the slot and makes the entry most recent; cmd insert
// refreshes a present key, or takes a fresh slot while slots remain, or
// else reuses the least recent slot and reports any valid key it evicted;
// cmd clear drops every mapping but keeps order and allocation count.
// Response channel: rsp_valid / rsp_stall carry rsp, one per request,
// in order.
// The request waits in the request register until the output register is
// free or its response is taken; the update then runs and the response is registered there.
// The request register holds one request until that update, so no new
// request is taken before it; the recency list is a chain of cells, one
// per entry, that compare the key in parallel and shift away from the
// head in the update cycle.
// A stalled response holds in the output register; one more request is
// taken meanwhile and waits until the response leaves.
// Reset empties the list: no valid mapping, no allocated slot.
`default_nettype none
module lru_tag_replacement_unit import lrut_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic             req_valid_s1;
	req_t             req_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] count_q;

	logic                go;
	logic                full;
	logic [KEY_BITS-1:0] key;
	ctl_t                ctl;
	stat_t               stat;
	rsp_t                res;
	logic                alloc;

	assign req_stall = req_valid_s1;
	assign go        = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign full      = (count_q == CNT_W'(ENTRIES));
	assign key       = req_s1.key[KEY_BITS-1:0];

	always_comb begin
		ctl   = '0;
		res   = '0;
		alloc = 1'b0;
		case (req_s1.cmd)
			CMD_LOOKUP: begin
				if (stat.hit) begin
					ctl.shift_hit = go;
					ctl.head      = stat.hit_entry;
					res.hit       = 1'b1;
					res.slot      = OSLOT_W'(stat.hit_entry.slot);
				end
			end
			CMD_INSERT: begin
				if (stat.hit) begin
					ctl.shift_hit = go;
					ctl.head      = stat.hit_entry;
					res.hit       = 1'b1;
					res.slot      = OSLOT_W'(stat.hit_entry.slot);
				end else if (!full) begin
					ctl.shift_all = go;
					ctl.head      = '{key: key, slot: count_q[SLOT_W-1:0], valid: 1'b1};
					res.slot      = OSLOT_W'(count_q[SLOT_W-1:0]);
					alloc         = go;
				end else begin
					ctl.shift_all     = go;
					ctl.head          = '{key: key, slot: stat.last.slot, valid: 1'b1};
					res.slot          = OSLOT_W'(stat.last.slot);
					res.displaced     = stat.last.valid;
					res.displaced_key = stat.last.valid ? KEY_W'(stat.last.key) : '0;
				end
			end
			CMD_CLEAR: begin
				ctl.clear = go;
			end
			default: begin
			end
		endcase
	end

	lrut_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.key   (key),
		.ctl   (ctl),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
			count_q      <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				req_valid_s1 <= 1'b1;
			end else if (go) begin
				req_valid_s1 <= 1'b0;
			end
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (alloc) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (go) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== sv/lrut_check.sv =====
`default_nettype none
module lrut_check import lrut_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken before update");

	a_disp_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.displaced |-> !rsp.hit)
		else $error("eviction reported on a hit");

	a_disp_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.displaced |-> rsp.displaced_key == '0)
		else $error("evicted key without eviction");

endmodule

bind lru_tag_replacement_unit lrut_check u_check (.*);
`default_nettype wire
